### rtl/lds_pkg.sv
// Shared constants, transaction types and correction-table builder for the log-domain adder.
package lds_pkg;

    // Fixed-point format of log values.
    localparam int LOG_W                  = 32;
    localparam int FRACTION_BITS          = 16;
    localparam int CORRECTION_TABLE_DEPTH = 1024;

    // Table step is 1/64, so the index is the difference shifted down by this amount.
    localparam int STEP_SHIFT = FRACTION_BITS - 6;
    // Width of the unclipped index, and of the address actually used.
    localparam int IDXF_W     = LOG_W - STEP_SHIFT;
    localparam int IDX_W      = $clog2(CORRECTION_TABLE_DEPTH);
    // Corrections stay within (-8, 8).
    localparam int TBL_W      = FRACTION_BITS + 4;

    localparam logic signed [LOG_W-1:0] LOG_ZERO = {1'b1, {(LOG_W-1){1'b0}}};
    localparam logic signed [LOG_W-1:0] TOP_CODE = {1'b0, {(LOG_W-1){1'b1}}};

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_SUB  = 2'd1,
        MODE_DIFF = 2'd2,
        MODE_SUM  = 2'd3
    } lds_mode_t;

    typedef struct packed {
        lds_mode_t               mode;
        logic signed [LOG_W-1:0] operand_a;
        logic signed [LOG_W-1:0] operand_b;
        logic                    start_sum;
    } lds_item_t;

    typedef struct packed {
        logic signed [LOG_W-1:0] result;
        logic                    order_error;
    } lds_result_t;

    typedef logic [CORRECTION_TABLE_DEPTH-1:0][TBL_W-1:0] corr_table_t;

    // ------------------------------------------------------------------
    // Elaboration-time table generation in Q60 working precision.
    // ------------------------------------------------------------------
    localparam int          WBITS = 60;
    localparam logic [63:0] WONE  = 64'd1 << WBITS;

    // (a * b) / 2^60, rounded to nearest
    function automatic logic [63:0] wmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (WBITS - 1));
        return p[WBITS+63:WBITS];
    endfunction

    // Plain restoring long division, quotient floor(n / d)
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            q = q << 1;
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // floor(n * 2^60 / d) for n < d
    function automatic logic [63:0] wdiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] r;
        logic [63:0] q;
        r = n;
        q = '0;
        for (int k = 0; k < WBITS; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2 * atanh(z), series
    function automatic logic [63:0] two_atanh(input logic [63:0] z);
        logic [63:0] s;
        logic [63:0] z2;
        logic [63:0] p;
        logic        done;
        s    = z;
        z2   = wmul(z, z);
        p    = z;
        done = 1'b0;
        for (int n = 3; n < 200; n += 2)
        begin
            if (!done)
            begin
                p = wmul(p, z2);
                if (p == 64'd0)
                    done = 1'b1;
                else
                    s = s + udiv(p, 64'(n));
            end
        end
        return s << 1;
    endfunction

    // ln(w), w in Q60, result two's complement Q60
    function automatic logic [63:0] wlog(input logic [63:0] w_in, input logic [63:0] ln2);
        logic [63:0] w;
        logic [63:0] k;
        w = w_in;
        k = '0;
        if (w == 64'd0)
            return 64'd0;
        for (int j = 0; j < 64; j++)
        begin
            if (w < WONE)
            begin
                w = w << 1;
                k = k + 64'd1;
            end
        end
        return two_atanh(wdiv(w - WONE, w + WONE)) - k * ln2;
    endfunction

    // Q60 to FRACTION_BITS, nearest, ties away from zero
    function automatic logic [63:0] to_frac(input logic [63:0] x);
        logic [63:0] half;
        half = 64'd1 << (WBITS - FRACTION_BITS - 1);
        if (!x[63])
            return (x + half) >> (WBITS - FRACTION_BITS);
        return -(((-x) + half) >> (WBITS - FRACTION_BITS));
    endfunction

    // ln(1 + e^-x) or ln(1 - e^-x), sampled at the middle of each 1/64 step
    function automatic corr_table_t build_corr_table(input logic sub_sel);
        corr_table_t tbl;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] v;
        logic [63:0] ln2;
        logic [63:0] entry;
        logic        done;
        t    = WONE >> 7;
        s    = WONE;
        term = WONE;
        done = 1'b0;
        // e^-(1/128) by Taylor series
        for (int n = 1; n < 40; n++)
        begin
            if (!done)
            begin
                term = udiv(wmul(term, t), 64'(n));
                if (term == 64'd0)
                    done = 1'b1;
                else if (n % 2 == 1)
                    s = s - term;
                else
                    s = s + term;
            end
        end
        q   = wmul(s, s);
        ln2 = two_atanh(wdiv(WONE, 64'd3 * WONE));
        v   = s;
        for (int i = 0; i < CORRECTION_TABLE_DEPTH; i++)
        begin
            entry  = to_frac(wlog(sub_sel ? (WONE - v) : (WONE + v), ln2));
            tbl[i] = entry[TBL_W-1:0];
            v      = wmul(v, q);
        end
        return tbl;
    endfunction

    localparam corr_table_t ADD_TABLE = build_corr_table(1'b0);
    localparam corr_table_t SUB_TABLE = build_corr_table(1'b1);

endpackage

### rtl/log_domain_add_sub.sv
// Top level of the log-domain add/sub/diff/sum unit.
//
// Log-domain arithmetic on natural-log values in signed Q15.16; the most negative code is
// log zero. Each op transaction carries a mode (add, sub, diff, sum), two operands and a
// start flag; each one produces exactly one res transaction holding the saturated result
// and an order error flag (sub with operand_a below operand_b). Throughput is one
// transaction per clock in every mode while res is not stalled, including back-to-back sum
// transactions: the accumulator loop closes within the single compare / subtract / table read /
// add path between the op stage register and the res register. When res is not stalled, an
// accepted op passes through the stage register into the res register, which raises res_valid.
// op_stall rises only while both the stage register and the res register are full and res
// is stalled. The correction tables (ln(1+e^-d) and ln(1-e^-d), 1/64 steps) are constants
// computed at elaboration.
module log_domain_add_sub (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    output logic                 op_stall,
    input  lds_pkg::lds_item_t   op,
    output logic                 res_valid,
    input  logic                 res_stall,
    output lds_pkg::lds_result_t res
);
    import lds_pkg::*;

    // op stage
    logic                    stage_valid_reg;
    logic                    stage_valid_next;
    lds_item_t               stage_reg;

    // res stage
    logic                    res_valid_reg;
    logic                    res_valid_next;
    lds_result_t             res_reg;

    // running log sum
    logic signed [LOG_W-1:0] acc_reg;
    logic signed [LOG_W-1:0] acc_next;

    lds_result_t             alu_res;
    logic                    advance;
    logic                    op_take;
    logic                    stage_fire;

    // stage moves forward whenever the res register is empty or being drained
    assign advance    = !res_valid_reg || !res_stall;
    assign op_stall   = stage_valid_reg && !advance;
    assign op_take    = op_valid && !op_stall;
    assign stage_fire = stage_valid_reg && advance;

    lds_alu u_alu (
        .item (stage_reg),
        .acc  (acc_reg),
        .res  (alu_res)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (!op_stall)
            stage_valid_next = op_valid;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = stage_valid_reg;

        // accumulator commits only when its transaction leaves the stage
        acc_next = acc_reg;
        if (stage_fire && (stage_reg.mode == MODE_SUM))
            acc_next = alu_res.result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
            acc_reg         <= LOG_ZERO;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
            acc_reg         <= acc_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (op_take)
            stage_reg <= op;
        if (stage_fire)
            res_reg <= alu_res;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### rtl/lds_corr.sv
// Correction lookup: table index from the operand difference, range check, table read.
module lds_corr (
    input  logic [lds_pkg::LOG_W-1:0]        diff,
    input  logic                             sub_sel,
    output logic signed [lds_pkg::TBL_W-1:0] corr,
    output logic                             in_range
);
    import lds_pkg::*;

    logic [IDXF_W-1:0] idx_full;
    logic [IDX_W-1:0]  idx;

    assign idx_full = IDXF_W'(diff >> STEP_SHIFT);
    assign in_range = idx_full < IDXF_W'(CORRECTION_TABLE_DEPTH);
    assign idx      = idx_full[IDX_W-1:0];

    // both tables share the address; only one feeds the adder
    assign corr = sub_sel ? $signed(SUB_TABLE[idx]) : $signed(ADD_TABLE[idx]);

endmodule

### rtl/lds_alu.sv
// Single-pass log-domain datapath: compare, difference, correction, add, saturate.
module lds_alu (
    input  lds_pkg::lds_item_t               item,
    input  logic signed [lds_pkg::LOG_W-1:0] acc,
    output lds_pkg::lds_result_t             res
);
    import lds_pkg::*;

    logic signed [LOG_W-1:0] x;
    logic signed [LOG_W-1:0] y;
    logic                    x_lt_y;
    logic signed [LOG_W-1:0] hi;
    logic signed [LOG_W-1:0] lo;
    logic [LOG_W-1:0]        diff;
    logic                    sub_sel;
    logic signed [TBL_W-1:0] corr;
    logic                    in_range;
    logic signed [LOG_W:0]   sum_wide;
    logic signed [LOG_W-1:0] sum_sat;
    logic signed [LOG_W-1:0] add_val;
    logic signed [LOG_W-1:0] sub_val;

    // sum mode folds operand_a into the accumulator
    assign x = (item.mode == MODE_SUM) ? acc : item.operand_a;
    assign y = (item.mode == MODE_SUM) ? item.operand_a : item.operand_b;

    assign x_lt_y = x < y;
    assign hi     = x_lt_y ? y : x;
    assign lo     = x_lt_y ? x : y;
    assign diff   = $unsigned(hi) - $unsigned(lo);

    assign sub_sel = (item.mode == MODE_SUB) || (item.mode == MODE_DIFF);

    lds_corr u_corr (
        .diff     (diff),
        .sub_sel  (sub_sel),
        .corr     (corr),
        .in_range (in_range)
    );

    assign sum_wide = {hi[LOG_W-1], hi} + (LOG_W+1)'(corr);

    always_comb
    begin
        if (sum_wide > (LOG_W+1)'(TOP_CODE))
            sum_sat = TOP_CODE;
        else if (sum_wide < (LOG_W+1)'(LOG_ZERO))
            sum_sat = LOG_ZERO;
        else
            sum_sat = sum_wide[LOG_W-1:0];
    end

    assign add_val = ((lo == LOG_ZERO) || !in_range) ? hi : sum_sat;
    assign sub_val = (hi == lo) ? LOG_ZERO
                   : ((lo == LOG_ZERO) || !in_range) ? hi : sum_sat;

    always_comb
    begin
        res.order_error = 1'b0;
        unique case (item.mode)
            MODE_ADD:  res.result = add_val;
            MODE_SUB:
            begin
                if (x_lt_y)
                begin
                    res.result      = LOG_ZERO;
                    res.order_error = 1'b1;
                end
                else
                begin
                    res.result = sub_val;
                end
            end
            MODE_DIFF: res.result = sub_val;
            MODE_SUM:  res.result = item.start_sum ? item.operand_a : add_val;
            default:   res.result = add_val;
        endcase
    end

endmodule

### rtl/lds_checker.sv
// Port-level assertions for log_domain_add_sub and the bind that attaches them.
module lds_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 op_valid,
    input logic                 op_stall,
    input lds_pkg::lds_item_t   op,
    input logic                 res_valid,
    input logic                 res_stall,
    input lds_pkg::lds_result_t res
);
    import lds_pkg::*;

    // stalled op transaction holds
    a_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op_stall |=> op_valid && $stable(op))
        else $error("op changed while stalled");

    // stalled res transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("res changed while stalled");

    // upstream is held off only by a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        op_stall |-> res_valid && res_stall)
        else $error("op_stall without output backpressure");

    // accepted op reaches res once the output drains
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && !op_stall) ##1 !res_stall |=> res_valid)
        else $error("accepted op did not reach res");

    // order error always comes with a log-zero result
    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.order_error |-> res.result == LOG_ZERO)
        else $error("order error with non log-zero result");

endmodule

bind log_domain_add_sub lds_checker u_lds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op        (op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
